/* rtl/log_power_peak_hold_display_assert.svh */
// Assertion macros used by the top-level RTL file.
// LPHD_ASSERT: checked on rising clk, disabled while rst_n is low.
// LPHD_ASSERT_RST: checked on rising clk, also during reset.
`ifndef LOG_POWER_PEAK_HOLD_DISPLAY_ASSERT_SVH
`define LOG_POWER_PEAK_HOLD_DISPLAY_ASSERT_SVH

`ifndef SYNTH
`define LPHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPHD_ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

/* rtl/lphd_pkg.sv */
`default_nettype none

package lphd_pkg;

  localparam int NUM_COLUMNS   = 128;
  localparam int CENTER_COLUMN = 63;

  localparam int COL_W  = 7;
  localparam int PWR_W  = 16;
  localparam int LVL_W  = 8;
  localparam int GAIN_W = 3;
  localparam int POS_W  = 4;
  localparam int FRAC_W = 4;
  localparam int IDX_W  = $clog2(NUM_COLUMNS);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(3);

  // 16*log2(1 + k/64), rounded down
  localparam logic [FRAC_W-1:0] FRAC_LUT [64] = '{
    4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd1,  4'd2,  4'd2,
    4'd2,  4'd3,  4'd3,  4'd3,  4'd3,  4'd4,  4'd4,  4'd4,
    4'd5,  4'd5,  4'd5,  4'd6,  4'd6,  4'd6,  4'd6,  4'd7,
    4'd7,  4'd7,  4'd7,  4'd8,  4'd8,  4'd8,  4'd8,  4'd9,
    4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd14, 4'd14,
    4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
  };

  // Read/write request to the display store
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [LVL_W-1:0] wr_data;
  } lphd_mem_req_t;

endpackage

`default_nettype wire

/* rtl/log_power_peak_hold_display.sv */
// Channel | Signals                              | Direction
// --------+--------------------------------------+----------
// in      | in_valid, in_stall, in_column, in_power | power sample in
// out     | out_valid, out_stall, out_column, out_level | column level out
// cfg     | cfg_wr_en, cfg_wr_data               | gain_shift write
//
// One transaction per cycle sustained unless out stalls; an input fills the
// update stage, then the output register (log, store read; update, store write).
// The store is a 128x8 array read and written once per cycle; back-to-back
// hits on one column are forwarded from the write port.
// Synchronous active-low reset clears all store entries at once (valid bits).
// in_stall rises only when the update stage is full and out is stalled.
`default_nettype none

`include "log_power_peak_hold_display_assert.svh"

module log_power_peak_hold_display (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [lphd_pkg::GAIN_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lphd_pkg::COL_W-1:0]    in_column,
  input  wire logic [lphd_pkg::PWR_W-1:0]    in_power,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [lphd_pkg::COL_W-1:0]    out_column,
  output logic      [lphd_pkg::LVL_W-1:0]    out_level
);
  import lphd_pkg::*;

  logic [GAIN_W-1:0] gain_r;
  logic              s1_valid_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [LVL_W-1:0]  s1_val_r;
  logic              out_valid_r;
  logic [COL_W-1:0]  out_col_r;
  logic [LVL_W-1:0]  out_lvl_r;

  logic              accept;
  logic              advance;
  logic [LVL_W-1:0]  log_val;
  logic [LVL_W-1:0]  old_val;
  logic              in_range;
  logic [LVL_W-1:0]  level_nxt;
  lphd_mem_req_t     mem_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  lphd_log u_log (
    .power      (in_power),
    .gain_shift (gain_r),
    .log_val    (log_val)
  );

  assign in_range = {1'b0, s1_col_r} < (COL_W+1)'(NUM_COLUMNS);

  // fast attack, slow release; center column pinned to zero
  always_comb begin
    if (!in_range || s1_col_r == COL_W'(CENTER_COLUMN)) begin
      level_nxt = '0;
    end else if (s1_val_r >= old_val) begin
      level_nxt = s1_val_r;
    end else begin
      level_nxt = old_val - LVL_W'(1);
    end
  end

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.rd_idx  = in_column[IDX_W-1:0];
    mem_req.wr_en   = advance && in_range;
    mem_req.wr_idx  = s1_col_r[IDX_W-1:0];
    mem_req.wr_data = level_nxt;
  end

  lphd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .old_val (old_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= in_column;
      s1_val_r <= log_val;
    end
    if (advance) begin
      out_col_r <= s1_col_r;
      out_lvl_r <= level_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_column = out_col_r;
  assign out_level  = out_lvl_r;

  `LPHD_ASSERT(a_center_zero, clk, rst_n, out_valid && out_column == COL_W'(CENTER_COLUMN) |-> out_level == '0, "center column level not zero")
  `LPHD_ASSERT(a_accept_fills, clk, rst_n, accept |=> s1_valid_r, "accepted transaction lost in update stage")
  `LPHD_ASSERT(a_out_drains, clk, rst_n, out_valid && !out_stall && !advance |=> !out_valid, "result repeated after being taken")
  `LPHD_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid && !s1_valid_r, "pipeline not empty after reset")

endmodule

`default_nettype wire

/* rtl/lphd_log.sv */
`default_nettype none

module lphd_log (
  input  wire logic [lphd_pkg::PWR_W-1:0]  power,
  input  wire logic [lphd_pkg::GAIN_W-1:0] gain_shift,
  output logic      [lphd_pkg::LVL_W-1:0]  log_val
);
  import lphd_pkg::*;

  logic [POS_W-1:0] pos;
  logic [PWR_W-1:0] norm;
  logic [5:0]       frac_idx;
  logic [LVL_W-1:0] raw;

  // leading-one position
  always_comb begin
    pos = '0;
    for (int b = 0; b < PWR_W; b++) begin
      if (power[b]) begin
        pos = POS_W'(b);
      end
    end
  end

  // put the leading one at the MSB; the six bits below index the table
  assign norm     = power << (~pos);
  assign frac_idx = norm[PWR_W-2 -: 6];

  always_comb begin
    if (power == '0) begin
      raw = '0;
    end else begin
      raw = {pos, FRAC_LUT[frac_idx]};
    end
  end

  assign log_val = raw >> gain_shift;

endmodule

`default_nettype wire

/* rtl/lphd_store.sv */
`default_nettype none

module lphd_store (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lphd_pkg::lphd_mem_req_t      req,
  output logic      [lphd_pkg::LVL_W-1:0]   old_val
);
  import lphd_pkg::*;

  logic [LVL_W-1:0]       mem [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0] vbits_r;
  logic [LVL_W-1:0]       rd_r;
  logic                   vld_r;
  logic                   fwd_hit_r;
  logic [LVL_W-1:0]       fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_idx] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_r <= mem[req.rd_idx];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbits_r <= '0;
    end else if (req.wr_en) begin
      vbits_r[req.wr_idx] <= 1'b1;
    end
  end

  // a write in the same cycle as the read of that entry is forwarded
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      vld_r      <= vbits_r[req.rd_idx];
      fwd_hit_r  <= req.wr_en && (req.wr_idx == req.rd_idx);
      fwd_data_r <= req.wr_data;
    end
  end

  always_comb begin
    if (fwd_hit_r) begin
      old_val = fwd_data_r;
    end else if (vld_r) begin
      old_val = rd_r;
    end else begin
      old_val = '0;
    end
  end

endmodule

`default_nettype wire

/* test/tb_log_power_peak_hold_display.sv */
`default_nettype none

module tb_log_power_peak_hold_display;
  timeunit 1ns;
  timeprecision 1ps;

  import lphd_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [PWR_W-1:0] power;
  } power_sample_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [LVL_W-1:0] level;
  } column_level_t;

  // 16*log2(1 + k/64), rounded down
  localparam logic [3:0] LOG_FRAC [64] = '{
    4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd1,  4'd2,  4'd2,
    4'd2,  4'd3,  4'd3,  4'd3,  4'd3,  4'd4,  4'd4,  4'd4,
    4'd5,  4'd5,  4'd5,  4'd6,  4'd6,  4'd6,  4'd6,  4'd7,
    4'd7,  4'd7,  4'd7,  4'd8,  4'd8,  4'd8,  4'd8,  4'd9,
    4'd9,  4'd9,  4'd9,  4'd10, 4'd10, 4'd10, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12,
    4'd12, 4'd13, 4'd13, 4'd13, 4'd13, 4'd13, 4'd14, 4'd14,
    4'd14, 4'd14, 4'd14, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
  };

  localparam int RANDOM_PER_GAIN = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [GAIN_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COL_W-1:0] in_column = '0;
  logic [PWR_W-1:0] in_power = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COL_W-1:0] out_column;
  logic [LVL_W-1:0] out_level;

  power_sample_t pending_samples[$];
  column_level_t expected_levels[$];
  logic [LVL_W-1:0] peak_store [NUM_COLUMNS];
  logic [GAIN_W-1:0] gain_model = GAIN_RESET;
  logic steady = 1'b0;
  int err_count = 0;

  log_power_peak_hold_display dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_column  (in_column),
    .in_power   (in_power),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .out_level  (out_level)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [LVL_W-1:0] log_power_x16(input logic [PWR_W-1:0] p);
    int lead;
    int b;
    logic [PWR_W-1:0] norm;
    lead = 0;
    if (p == '0) return '0;
    for (b = 0; b < PWR_W; b++) begin
      if (p[b]) lead = b;
    end
    norm = (lead >= 6) ? (p >> (lead - 6)) : (p << (6 - lead));
    return LVL_W'(lead << 4) + LVL_W'(LOG_FRAC[norm[5:0]]);
  endfunction

  // fast attack, slow release; updates the model store
  function automatic column_level_t predict_level(input power_sample_t s);
    column_level_t r;
    logic [LVL_W-1:0] val;
    logic [LVL_W-1:0] old;
    val = log_power_x16(s.power) >> gain_model;
    r.column = s.column;
    r.level = '0;
    if (int'(s.column) < NUM_COLUMNS) begin
      old = peak_store[s.column];
      if (int'(s.column) == CENTER_COLUMN) r.level = '0;
      else if (val >= old) r.level = val;
      else if (old != '0) r.level = old - 1'b1;
      peak_store[s.column] = r.level;
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_levels.push_back(predict_level('{column: in_column, power: in_power}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
          in_valid <= 1'b1;
          in_column <= pending_samples[0].column;
          in_power <= pending_samples[0].power;
          void'(pending_samples.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          $error("unexpected transaction: column %0d level %0d", out_column, out_level);
          err_count++;
        end else begin
          if (out_column !== expected_levels[0].column) begin
            $error("out_column: expected %0d, actual %0d", expected_levels[0].column,
                   out_column);
            err_count++;
          end
          if (out_level !== expected_levels[0].level) begin
            $error("out_level: expected %0d, actual %0d", expected_levels[0].level,
                   out_level);
            err_count++;
          end
          void'(expected_levels.pop_front());
        end
      end
      out_stall <= !steady && ($urandom_range(99) < 35);
    end
  end

  task automatic queue_sample(input int col, input int pw);
    pending_samples.push_back('{column: COL_W'(col), power: PWR_W'(pw)});
  endtask

  // sender holds off until every expected transaction has come back
  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= g;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gain_model = g;
  endtask

  initial begin
    logic [GAIN_W-1:0] gain_order [8];
    int prev_col;
    int col;
    int pw;
    int pick;
    gain_order = '{3'd7, 3'd4, 3'd1, 3'd2, 3'd5, 3'd6, 3'd0, 3'd3};
    for (int k = 0; k < NUM_COLUMNS; k++) peak_store[k] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset gain: attack then decay
    queue_sample(10, 'hFFFF);
    queue_sample(10, 0);
    queue_sample(10, 0);
    queue_sample(127, 'h0100);
    wait_drained();

    set_gain(3'd0);
    queue_sample(0, 0);
    queue_sample(0, 'hFFFF);
    queue_sample(0, 1);
    queue_sample(0, 1);
    queue_sample(0, 'hFFFF);
    queue_sample(127, 'h8000);
    queue_sample(127, 'h4000);
    queue_sample(CENTER_COLUMN, 'hFFFF);
    queue_sample(CENTER_COLUMN, 'h0001);
    queue_sample(1, 1);
    queue_sample(1, 2);
    queue_sample(2, 'h003F);
    queue_sample(3, 'h007F);
    queue_sample(4, 'h0040);
    queue_sample(5, 'h00FF);
    queue_sample(6, 'h1234);
    queue_sample(7, 'hAAAA);
    queue_sample(8, 'h5555);
    queue_sample(9, 'h7FFF);
    wait_drained();

    prev_col = 0;
    for (int ph = 0; ph < 8; ph++) begin
      set_gain(gain_order[ph]);
      steady = (ph == 1);
      for (int n = 0; n < RANDOM_PER_GAIN; n++) begin
        pick = $urandom_range(9);
        if (pick < 3) col = prev_col;
        else if (pick == 3) col = CENTER_COLUMN;
        else if (pick == 4) col = $urandom_range(1) ? NUM_COLUMNS - 1 : 0;
        else col = $urandom_range(NUM_COLUMNS - 1);
        // spread magnitudes so both attack and decay happen often
        pick = $urandom_range(9);
        if (pick == 0) pw = 0;
        else if (pick < 5) pw = $urandom_range(16'hFFFF);
        else pw = $urandom_range(16'hFFFF) >> $urandom_range(15, 1);
        queue_sample(col, pw);
        prev_col = col;
      end
      wait_drained();
    end
    steady = 1'b0;

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
